### hw/rtl/ole_pkg.sv
// ole_pkg: operation and status codes and the shared types of the ordered list engine
// no dependencies
package ole_pkg;

    typedef enum logic [3:0] {
        OP_PUSH_FRONT = 4'd0,
        OP_PUSH_BACK  = 4'd1,
        OP_OVERWRITE  = 4'd2,
        OP_INSERT     = 4'd3,
        OP_DELETE     = 4'd4,
        OP_POP        = 4'd5,
        OP_SEARCH     = 4'd6,
        OP_READ       = 4'd7,
        OP_CLEAR      = 4'd8
    } t_op;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_SHIFT_DOWN,
        S_DONE
    } t_state;

    // command and result transactions as carried on the two channels
    typedef struct packed {
        logic [3:0]  operation;
        logic [6:0]  position;
        logic [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic [31:0] result_value;
        logic [1:0]  status;
        logic [6:0]  entry_count;
    } t_res;

endpackage

### hw/rtl/ole_if.sv
// ole_if: valid/ready channel carrying a generic payload
// depends on nothing; payload type given as a parameter
interface ole_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/ole_ram.sv
// ole_ram: generic single-port-write, single-port-read RAM with registered read
// no dependencies
module ole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/ordered_list_engine.sv
// ordered_list_engine: bounded ordered list of signed 32-bit values
// depends on ole_pkg, ole_if, ole_ram
//
// usage
//   commands arrive on the sink channel (operation, position, value); one result
//   transaction (result_value, status, entry_count) leaves on the source channel
//   for every command.
//   entries sit packed in one RAM with registered read. a sequencer
//   reads an entry, compares or moves it and writes it back, one entry a cycle.
//   push back, overwrite, clear and failed commands finish straight from idle;
//   read goes through one RAM read; pop, delete and search walk the entries from
//   the position or the head; push front and insert move entries up from the tail
//   to the position, then write the new value. the RAM port (one read and one
//   write a cycle) sets the pace of the walks. one command is in work at a time;
//   the next is taken in the cycle in which the previous result leaves, so
//   commands done from idle run one per cycle while the receiver takes results.
//   reset clears the entry count and the sequencer; RAM contents stay as they
//   are and are never read beyond the count.
//   a stalled receiver holds the result register; new commands wait.
module ordered_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ole_if.sink   i_cmd,
    ole_if.source o_res
);
    import ole_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // command register
    logic [3:0]  r_op,  n_op;
    logic [CW-1:0] r_pos, n_pos;
    logic [31:0] r_val, n_val;
    // list count and walk pointer
    logic [CW-1:0] r_total, n_total;
    logic [CW-1:0] r_idx,   n_idx;
    t_state        r_state;
    // result register
    logic          r_out_valid, n_out_valid;
    logic [31:0]   r_res, n_res;
    logic [1:0]    r_st,  n_st;
    logic [CW-1:0] r_cnt, n_cnt;
    // popped value held while the rest moves down
    logic [31:0]   r_pop;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata, rdata;

    logic [3:0]  in_op;
    logic [6:0]  in_pos;
    logic [31:0] in_val;

    // sequencing decisions from the datapath
    logic [1:0]    fin_st;
    logic          fin;
    logic [31:0]   fin_res;
    logic [CW-1:0] fin_cnt;
    logic          go_state_valid;
    t_state        go_state;
    t_state        next_st;

    logic [CW-1:0] wide_pos;
    logic          pos_big;   // position beyond what CW can hold

    assign in_op  = i_cmd.data.operation;
    assign in_pos = i_cmd.data.position;
    assign in_val = i_cmd.data.value;

    ole_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // idle and the result register free (or emptying this cycle)
    assign i_cmd.ready = (r_state == S_IDLE) && (!r_out_valid || o_res.ready);

    assign o_res.valid             = r_out_valid;
    assign o_res.data.result_value = r_res;
    assign o_res.data.status       = r_st;
    assign o_res.data.entry_count  = 7'(r_cnt);

    assign wide_pos = CW'(in_pos);

    always_comb begin
        pos_big = 1'b0;
        if (CW < 7) begin
            pos_big = (in_pos >> CW) != 7'd0;
        end
    end

    // datapath and sequencing
    always_comb begin
        n_op = r_op; n_pos = r_pos; n_val = r_val;
        n_total = r_total; n_idx = r_idx;
        n_out_valid = r_out_valid && !o_res.ready;
        n_res = r_res; n_st = r_st; n_cnt = r_cnt;
        we = 1'b0; waddr = '0; wdata = r_val; raddr = '0;
        fin = 1'b0; fin_st = ST_OK; fin_res = '0; fin_cnt = r_total;
        go_state_valid = 1'b0; go_state = S_IDLE;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid && i_cmd.ready) begin
                    n_op = in_op; n_pos = wide_pos; n_val = in_val;
                    go_state_valid = 1'b1;
                    case (in_op)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            if (r_total >= CW'(CAPACITY)) begin
                                fin = 1'b1; fin_st = ST_FULL;
                            end else if (in_op == OP_PUSH_BACK || r_total == '0) begin
                                we = 1'b1; waddr = AW'(r_total); wdata = in_val;
                                fin = 1'b1; fin_cnt = r_total + 1'b1;
                                n_total = r_total + 1'b1;
                            end else begin
                                n_pos = '0;
                                n_idx = r_total;     // write slot r_idx from r_idx-1
                                raddr = AW'(r_total - 1'b1);
                                go_state = S_SHIFT_UP;
                            end
                        end
                        OP_INSERT: begin
                            if (pos_big || wide_pos > r_total) begin
                                fin = 1'b1; fin_st = ST_RANGE;
                            end else if (r_total >= CW'(CAPACITY)) begin
                                fin = 1'b1; fin_st = ST_FULL;
                            end else if (wide_pos == r_total) begin
                                we = 1'b1; waddr = AW'(r_total); wdata = in_val;
                                fin = 1'b1; fin_cnt = r_total + 1'b1;
                                n_total = r_total + 1'b1;
                            end else begin
                                n_idx = r_total;
                                raddr = AW'(r_total - 1'b1);
                                go_state = S_SHIFT_UP;
                            end
                        end
                        OP_OVERWRITE: begin
                            if (pos_big || wide_pos >= r_total) begin
                                fin = 1'b1; fin_st = ST_RANGE;
                            end else begin
                                we = 1'b1; waddr = AW'(wide_pos); wdata = in_val;
                                fin = 1'b1;
                            end
                        end
                        OP_POP, OP_READ: begin
                            if (pos_big || wide_pos >= r_total) begin
                                fin = 1'b1; fin_st = ST_RANGE;
                            end else begin
                                // read entry at pos, then (pop) pull the rest down
                                raddr = AW'(wide_pos);
                                n_idx = wide_pos + 1'b1;
                                go_state = S_SHIFT_DOWN;
                            end
                        end
                        OP_DELETE, OP_SEARCH: begin
                            if (r_total == '0) begin
                                fin = 1'b1; fin_st = ST_MISSING;
                            end else begin
                                raddr = '0;
                                n_idx = CW'(1);
                                go_state = S_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            fin = 1'b1; fin_cnt = '0; n_total = '0;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                    if (fin) go_state_valid = 1'b0;
                end
            end
            S_SCAN: begin
                // rdata holds entry r_idx-1
                if (rdata == r_val) begin
                    if (r_op == OP_SEARCH) begin
                        fin = 1'b1;
                    end else begin
                        n_pos = r_idx - 1'b1;
                        go_state_valid = 1'b1;
                        if (r_idx >= r_total) begin
                            fin = 1'b1; fin_cnt = r_total - 1'b1;
                            n_total = r_total - 1'b1;
                            go_state_valid = 1'b0;
                        end else begin
                            raddr = AW'(r_idx);
                            n_idx = r_idx + 1'b1;
                            go_state = S_SHIFT_DOWN;
                        end
                    end
                end else if (r_idx >= r_total) begin
                    fin = 1'b1; fin_st = ST_MISSING;
                end else begin
                    raddr = AW'(r_idx);
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SHIFT_UP: begin
                // rdata = entry r_idx-1, goes to slot r_idx
                we = 1'b1; waddr = AW'(r_idx); wdata = rdata;
                if (r_idx - 1'b1 == r_pos) begin
                    go_state_valid = 1'b1; go_state = S_DONE;
                    n_idx = r_pos;
                end else begin
                    raddr = AW'(r_idx - 2'd2);
                    n_idx = r_idx - 1'b1;
                end
            end
            S_SHIFT_DOWN: begin
                // first pass (pop/read) rdata = entry at pos; later rdata = r_idx-1
                if (r_op == OP_READ) begin
                    fin = 1'b1; fin_res = rdata;
                end else begin
                    if (!(r_idx == r_pos + 1'b1 && r_op == OP_POP)) begin
                        we = 1'b1; waddr = AW'(r_idx - 2'd2); wdata = rdata;
                    end
                    if (r_idx >= r_total) begin
                        fin = 1'b1; fin_cnt = r_total - 1'b1;
                        n_total = r_total - 1'b1;
                        fin_res = (r_op == OP_POP) ?
                                  ((r_idx == r_pos + 1'b1) ? rdata : r_pop) : '0;
                    end else begin
                        raddr = AW'(r_idx);
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_DONE: begin
                // gap open at r_pos
                we = 1'b1; waddr = AW'(r_pos); wdata = r_val;
                fin = 1'b1; fin_cnt = r_total + 1'b1;
                n_total = r_total + 1'b1;
            end
            default: ;
        endcase

        if (fin) begin
            n_out_valid = 1'b1;
            n_res = fin_res; n_st = fin_st; n_cnt = fin_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SHIFT_DOWN && r_idx == r_pos + 1'b1) begin
            r_pop <= rdata;
        end
    end

    // next state
    always_comb begin
        next_st = r_state;
        if (fin) begin
            next_st = S_IDLE;
        end else if (go_state_valid) begin
            next_st = go_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= next_st;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
        r_op  <= n_op;
        r_pos <= n_pos;
        r_val <= n_val;
        r_idx <= n_idx;
        r_res <= n_res;
        r_st  <= n_st;
        r_cnt <= n_cnt;
    end
endmodule

### hw/rtl/ole_checker.sv
// ole_checker: port-level checks on the ordered list engine
// depends on ole_pkg and ole_if; bound to ordered_list_engine
module ole_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic cmd_valid,
    input logic cmd_ready,
    input logic res_valid,
    input logic res_ready,
    input logic [1:0] res_status,
    input logic [6:0] res_count
);
    import ole_pkg::*;

    // a result that waits holds its status and count
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_count))
        else $error("result changed while stalled");

    // no command is taken while a stalled result waits
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |-> !cmd_ready)
        else $error("command taken over stalled result");

    // count never exceeds 64, the default list capacity
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> res_count <= 7'd64)
        else $error("entry count out of range");
endmodule

bind ordered_list_engine ole_checker u_ole_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .cmd_valid (i_cmd.valid),
    .cmd_ready (i_cmd.ready),
    .res_valid (o_res.valid),
    .res_ready (o_res.ready),
    .res_status(o_res.data.status),
    .res_count (o_res.data.entry_count)
);

### sim/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for ordered_list_engine, directed then random commands
// depends on ole_pkg, ole_if and ordered_list_engine
module testbench;
    import ole_pkg::*;

    localparam int DEPTH = 64;
    localparam int N_ITEMS = 1900;

    // list predictor with a queue of expected results
    class list_scoreboard;
        logic [31:0] entries[DEPTH];
        int          total;
        t_res        pending_q[$];
        int          mismatches;
        int          checked;
        int          op_seen[16];
        int          status_seen[4];

        function new();
            total = 0;
            mismatches = 0;
            checked = 0;
            foreach (op_seen[k]) op_seen[k] = 0;
            foreach (status_seen[k]) status_seen[k] = 0;
        endfunction

        function int find_value(logic [31:0] v);
            for (int k = 0; k < total; k++)
                if (entries[k] == v) return k;
            return total;
        endfunction

        function void open_slot(int p);
            for (int k = total; k > p; k--) entries[k] = entries[k - 1];
        endfunction

        function void close_slot(int p);
            for (int k = p; k + 1 < total; k++) entries[k] = entries[k + 1];
        endfunction

        // works out the result of one accepted command
        function void note_cmd(t_cmd c);
            t_res r;
            int   p;
            int   k;
            p = c.position;
            r.result_value = '0;
            r.status = ST_OK;
            op_seen[c.operation]++;
            case (c.operation)
                OP_PUSH_FRONT, OP_PUSH_BACK: begin
                    if (total >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        k = (c.operation == OP_PUSH_FRONT) ? 0 : total;
                        open_slot(k);
                        entries[k] = c.value;
                        total++;
                    end
                end
                OP_OVERWRITE: begin
                    if (p >= total) r.status = ST_RANGE;
                    else entries[p] = c.value;
                end
                OP_INSERT: begin
                    if (p > total) begin
                        r.status = ST_RANGE;
                    end else if (total >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        open_slot(p);
                        entries[p] = c.value;
                        total++;
                    end
                end
                OP_DELETE: begin
                    k = find_value(c.value);
                    if (k >= total) begin
                        r.status = ST_MISSING;
                    end else begin
                        close_slot(k);
                        total--;
                    end
                end
                OP_POP: begin
                    if (p >= total) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.result_value = entries[p];
                        close_slot(p);
                        total--;
                    end
                end
                OP_SEARCH: begin
                    if (find_value(c.value) >= total) r.status = ST_MISSING;
                end
                OP_READ: begin
                    if (p >= total) r.status = ST_RANGE;
                    else r.result_value = entries[p];
                end
                OP_CLEAR: total = 0;
                default: ;
            endcase
            r.entry_count = total[6:0];
            status_seen[r.status]++;
            pending_q.push_back(r);
        endfunction

        // compares one accepted result with the oldest expectation
        function void check_res(t_res got);
            t_res want;
            checked++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %h status %0d count %0d",
                             got.result_value, got.status, got.entry_count);
                return;
            end
            want = pending_q.pop_front();
            if (got.result_value !== want.result_value || got.status !== want.status
                    || got.entry_count !== want.entry_count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch %0d: expected value %h status %0d count %0d, got %h %0d %0d",
                             checked, want.result_value, want.status, want.entry_count,
                             got.result_value, got.status, got.entry_count);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ole_if #(.T(t_cmd)) cmd_if ();
    ole_if #(.T(t_res)) res_if ();

    ordered_list_engine #(.CAPACITY(DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .o_res   (res_if.source)
    );

    list_scoreboard board;
    bit             no_idle;      // set for the final stretch of the run
    bit             hold_request; // asks the receiver for one long hold-off
    logic [31:0]    value_pool[16];
    int             pool_idx;

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // result side: checks each transaction and picks the next ready level
    initial begin
        int idle_left;
        int hold_left;
        idle_left = 0;
        hold_left = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready)
                board.check_res(res_if.data);
            if (hold_request && hold_left == 0) begin
                hold_left = 400;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                // long stall so that the engine holds its result and backs off its input
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                res_if.ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                idle_left = $urandom_range(1, 13) - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // offers one command and waits for the handshake, with an optional burst of idling first
    task automatic send_cmd(t_cmd c);
        int gap;
        gap = (!no_idle && $urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= c;
        do @(posedge i_clk); while (!cmd_if.ready);
        board.note_cmd(c);
    endtask

    task automatic send_op(logic [3:0] op, int pos, logic [31:0] v);
        t_cmd c;
        c.operation = op;
        c.position  = pos[6:0];
        c.value     = v;
        send_cmd(c);
    endtask

    // value either fresh, an extreme or one seen before, so that searches and deletes hit
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return value_pool[$urandom_range(0, 15)];
        if (r < 50) return (r[0]) ? 32'h8000_0000 : 32'h7fff_ffff;
        return $urandom;
    endfunction

    // position mostly in or just beyond the list, sometimes anywhere the field allows
    function automatic int pick_position();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 127);
        return $urandom_range(0, board.total + 1);
    endfunction

    // op mix by phase: growing, mixed, shrinking
    function automatic logic [3:0] pick_op(int phase);
        int r;
        r = $urandom_range(0, 99);
        if (r < 1) return OP_CLEAR;
        if (r < 2) return 4'($urandom_range(9, 15));
        case (phase)
            0: begin
                if (r < 35) return OP_PUSH_BACK;
                if (r < 55) return OP_PUSH_FRONT;
                if (r < 75) return OP_INSERT;
            end
            2: begin
                if (r < 40) return OP_POP;
                if (r < 65) return OP_DELETE;
            end
            default: ;
        endcase
        return 4'($urandom_range(0, 7));
    endfunction

    initial begin
        t_cmd c;
        int   phase;
        board = new();
        no_idle = 1'b0;
        hold_request = 1'b0;
        pool_idx = 0;
        foreach (value_pool[k]) value_pool[k] = $urandom;
        cmd_if.valid = 1'b0;
        cmd_if.data  = '0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: errors on an empty list, extremes, every command, unknown codes
        send_op(OP_POP, 0, 32'h0);
        send_op(OP_READ, 0, 32'h0);
        send_op(OP_OVERWRITE, 0, 32'h1);
        send_op(OP_DELETE, 0, 32'h1);
        send_op(OP_SEARCH, 0, 32'h1);
        send_op(OP_INSERT, 1, 32'h2);
        send_op(OP_INSERT, 0, 32'h8000_0000);
        send_op(OP_PUSH_BACK, 0, 32'h7fff_ffff);
        send_op(OP_PUSH_FRONT, 0, 32'hffff_ffff);
        send_op(OP_INSERT, 3, 32'h0000_0000);
        send_op(OP_INSERT, 5, 32'h5);
        send_op(OP_READ, 127, 32'h0);
        send_op(OP_READ, 3, 32'h0);
        send_op(OP_OVERWRITE, 1, 32'h1234_5678);
        send_op(OP_SEARCH, 0, 32'h1234_5678);
        send_op(OP_SEARCH, 0, 32'h8000_0000);
        send_op(OP_DELETE, 0, 32'h7fff_ffff);
        send_op(OP_POP, 1, 32'h0);
        send_op(OP_POP, 2, 32'h0);
        send_op(4'd9, 0, 32'h0);
        send_op(4'd15, 127, 32'hffff_ffff);
        send_op(OP_CLEAR, 0, 32'h0);
        send_op(OP_READ, 0, 32'h0);

        // random: grow, mix and shrink phases so that full and empty lists both come up
        for (int n = 0; n < N_ITEMS; n++) begin
            phase = (n / 160) % 3;
            if (n == 600) hold_request = 1'b1;
            if (n == N_ITEMS - 200) no_idle = 1'b1;
            c.operation = pick_op(phase);
            c.position  = 7'(pick_position());
            c.value     = pick_value();
            if (c.operation inside {OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT, OP_OVERWRITE}) begin
                value_pool[pool_idx] = c.value;
                pool_idx = (pool_idx + 1) % 16;
            end
            send_cmd(c);
        end
        cmd_if.valid <= 1'b0;

        while (board.pending_q.size() != 0) @(posedge i_clk);
        repeat (2 * DEPTH + 20) @(posedge i_clk);

        $display("covered %0d commands: push %0d/%0d, insert %0d, pop %0d, delete %0d, search %0d",
                 board.checked, board.op_seen[OP_PUSH_FRONT], board.op_seen[OP_PUSH_BACK],
                 board.op_seen[OP_INSERT], board.op_seen[OP_POP], board.op_seen[OP_DELETE],
                 board.op_seen[OP_SEARCH]);
        $display("status counts: ok %0d, range %0d, missing %0d, full %0d; mismatches %0d",
                 board.status_seen[ST_OK], board.status_seen[ST_RANGE],
                 board.status_seen[ST_MISSING], board.status_seen[ST_FULL], board.mismatches);
        if (board.mismatches == 0 && board.pending_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog, well above the slowest correct run
    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule
